>>> rtl/bmps_pkg.sv
// Shared types, constants and codes of the bus master poll scheduler.
`timescale 1ns / 1ps
package bmps_pkg;

   localparam int MAX_CHANNELS = 64;
   localparam int CH_W         = 6;
   localparam int COUNT_W      = 7;
   localparam int TIMER_W      = 16;
   localparam int PAUSE_W      = 8;
   localparam int ERR_W        = 3;
   localparam int STATUS_W     = 2;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [TIMER_W-1:0] REQ_TIMER_RESET = TIMER_W'(5);
   localparam logic [TIMER_W-1:0] TIMER_MAX       = {TIMER_W{1'b1}};

   localparam logic [PAUSE_W-1:0] PAUSE_RESET     = PAUSE_W'(2);
   localparam logic [ERR_W-1:0]   ERR_LIMIT_RESET = ERR_W'(5);

   // item kinds
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_POLL  = 2'd1;
   localparam logic [1:0] ACT_SETUP = 2'd2;

   // channel status codes
   localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

   // register indexes (word address)
   localparam logic [1:0] REG_MASTER_ENABLE = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_REQUEST_PAUSE = 2'd2;
   localparam logic [1:0] REG_ERROR_LIMIT   = 2'd3;

   typedef struct packed {
      logic                master_enable;
      logic [COUNT_W-1:0]  channel_count;
      logic [PAUSE_W-1:0]  request_pause;
      logic [ERR_W-1:0]    error_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          action;
      logic                response_ok;
      logic [CH_W-1:0]     channel;
      logic [TIMER_W-1:0]  timeout_ticks;
   } req_item_type;

   typedef struct packed {
      logic                request_sent;
      logic                lap_complete;
      logic                response_accepted;
      logic                restore_settings;
      logic                timeout_marked;
      logic                raise_timeout_error;
      logic                clear_timeout_error;
      logic [STATUS_W-1:0] channel_status;
      logic [CH_W-1:0]     current_channel;
      logic                error_flag;
   } rsp_item_type;

endpackage

>>> rtl/bmps_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module bmps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bmps_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module bmps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bmps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bmps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output bmps_pkg::cfg_type                cfg
);
   import bmps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_hit;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_hit  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_MASTER_ENABLE: cfg_in.master_enable = pwdata[0];
            REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[COUNT_W-1:0];
            REG_REQUEST_PAUSE: cfg_in.request_pause = pwdata[PAUSE_W-1:0];
            REG_ERROR_LIMIT:   cfg_in.error_limit   = pwdata[ERR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MASTER_ENABLE: prdata = CSR_DATA_W'(cfg_ff.master_enable);
         REG_CHANNEL_COUNT: prdata = CSR_DATA_W'(cfg_ff.channel_count);
         REG_REQUEST_PAUSE: prdata = CSR_DATA_W'(cfg_ff.request_pause);
         REG_ERROR_LIMIT:   prdata = CSR_DATA_W'(cfg_ff.error_limit);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_enable <= 1'b0;
         cfg_ff.channel_count <= '0;
         cfg_ff.request_pause <= PAUSE_RESET;
         cfg_ff.error_limit   <= ERR_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bmps_engine.sv
// Poll engine: timers, round-robin pointer, channel tables and result logic.
`timescale 1ns / 1ps
module bmps_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  bmps_pkg::cfg_type      cfg,
   input  bmps_pkg::req_item_type item,
   input  logic                   go,
   output bmps_pkg::rsp_item_type result
);
   import bmps_pkg::*;

   localparam int SC_W = STATUS_W + ERR_W;

   // scalar state
   logic [TIMER_W-1:0]  req_tmr_ff, req_tmr_in;
   logic [TIMER_W-1:0]  rcv_tmr_ff, rcv_tmr_in;
   logic [CH_W-1:0]     next_ch_ff, next_ch_in;
   // working copy of the served channel's table entries
   logic [CH_W-1:0]     srv_ch_ff, srv_ch_in;
   logic [STATUS_W-1:0] srv_status_ff, srv_status_in;
   logic [ERR_W-1:0]    srv_cnt_ff, srv_cnt_in;
   logic                srv_flag_ff, srv_flag_in;

   // per-entry valid bits of the cleared-at-reset tables
   logic                sc_vld_ff [MAX_CHANNELS];
   logic                fl_vld_ff [MAX_CHANNELS];

   // prefetch of the next channel's entries
   logic                pf_to_fwd_ff, pf_to_fwd_in;
   logic [TIMER_W-1:0]  pf_to_data_ff, pf_to_data_in;
   logic                pf_sc_fwd_ff, pf_sc_fwd_in;
   logic [SC_W-1:0]     pf_sc_data_ff, pf_sc_data_in;
   logic                pf_sc_vld_ff, pf_sc_vld_in;
   logic                pf_fl_fwd_ff, pf_fl_fwd_in;
   logic                pf_fl_data_ff, pf_fl_data_in;
   logic                pf_fl_vld_ff, pf_fl_vld_in;

   logic [TIMER_W-1:0]  to_rd;
   logic [SC_W-1:0]     sc_rd;
   logic                fl_rd;
   logic [TIMER_W-1:0]  pf_timeout;
   logic [SC_W-1:0]     pf_sc;
   logic                pf_flag;

   // table writes
   logic                to_we;
   logic                sc_we;
   logic [SC_W-1:0]     sc_wd;

   logic [COUNT_W-1:0]  count_eff;
   logic [COUNT_W-1:0]  next_inc;
   logic [TIMER_W:0]    timer_sum;
   logic                poll_on;
   logic [STATUS_W-1:0] st_w;
   logic [ERR_W-1:0]    cnt_w;
   logic                flag_w;
   logic [TIMER_W-1:0]  rcv_w;
   rsp_item_type        res;

   assign pf_timeout = pf_to_fwd_ff ? pf_to_data_ff : to_rd;
   assign pf_sc      = pf_sc_fwd_ff ? pf_sc_data_ff : (pf_sc_vld_ff ? sc_rd : '0);
   assign pf_flag    = pf_fl_fwd_ff ? pf_fl_data_ff : (pf_fl_vld_ff && fl_rd);

   assign count_eff = (cfg.channel_count > COUNT_W'(MAX_CHANNELS)) ?
                      COUNT_W'(MAX_CHANNELS) : cfg.channel_count;
   assign next_inc  = COUNT_W'(next_ch_ff) + COUNT_W'(1);
   assign timer_sum = {1'b0, pf_timeout} + (TIMER_W+1)'(cfg.request_pause);
   assign poll_on   = cfg.master_enable && (count_eff != '0);

   always_comb begin
      req_tmr_in    = req_tmr_ff;
      rcv_tmr_in    = rcv_tmr_ff;
      next_ch_in    = next_ch_ff;
      srv_ch_in     = srv_ch_ff;
      srv_status_in = srv_status_ff;
      srv_cnt_in    = srv_cnt_ff;
      srv_flag_in   = srv_flag_ff;
      st_w          = srv_status_ff;
      cnt_w         = srv_cnt_ff;
      flag_w        = srv_flag_ff;
      rcv_w         = rcv_tmr_ff;
      to_we         = 1'b0;
      sc_we         = 1'b0;
      res           = '0;

      case (item.action)
         ACT_TICK: begin
            if (req_tmr_ff != '0) begin
               req_tmr_in = req_tmr_ff - TIMER_W'(1);
            end
            if (rcv_tmr_ff != '0) begin
               rcv_tmr_in = rcv_tmr_ff - TIMER_W'(1);
            end
         end
         ACT_POLL: begin
            if (poll_on) begin
               // start a request to the next channel
               if (req_tmr_ff == '0) begin
                  srv_ch_in = next_ch_ff;
                  if (next_inc >= count_eff) begin
                     next_ch_in       = '0;
                     res.lap_complete = 1'b1;
                  end else begin
                     next_ch_in = next_inc[CH_W-1:0];
                  end
                  res.request_sent = 1'b1;
                  st_w   = ST_PENDING;
                  cnt_w  = pf_sc[ERR_W-1:0];
                  flag_w = pf_flag;
                  rcv_w  = pf_timeout;
                  req_tmr_in = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
               end
               rcv_tmr_in = rcv_w;
               if (rcv_w != '0) begin
                  if (item.response_ok) begin
                     res.response_accepted   = 1'b1;
                     res.clear_timeout_error = 1'b1;
                     cnt_w      = '0;
                     flag_w     = 1'b0;
                     st_w       = ST_OK;
                     rcv_tmr_in = '0;
                  end
               end else begin
                  res.restore_settings = 1'b1;
                  if (st_w == ST_PENDING) begin
                     st_w               = ST_TIMEOUT;
                     res.timeout_marked = 1'b1;
                     if (cnt_w < cfg.error_limit) begin
                        cnt_w = cnt_w + ERR_W'(1);
                     end else begin
                        res.raise_timeout_error = 1'b1;
                        flag_w = 1'b1;
                     end
                  end
               end
               srv_status_in = st_w;
               srv_cnt_in    = cnt_w;
               srv_flag_in   = flag_w;
               sc_we         = 1'b1;
            end
         end
         ACT_SETUP: begin
            to_we = 1'b1;
            if (item.channel == srv_ch_ff) begin
               srv_status_in = ST_PENDING;
               srv_cnt_in    = '0;
            end
         end
         default: ;
      endcase

      // hold everything when no item moves
      if (!go) begin
         req_tmr_in    = req_tmr_ff;
         rcv_tmr_in    = rcv_tmr_ff;
         next_ch_in    = next_ch_ff;
         srv_ch_in     = srv_ch_ff;
         srv_status_in = srv_status_ff;
         srv_cnt_in    = srv_cnt_ff;
         srv_flag_in   = srv_flag_ff;
         to_we         = 1'b0;
         sc_we         = 1'b0;
      end

      res.channel_status  = srv_status_in;
      res.current_channel = srv_ch_in;
      res.error_flag      = srv_flag_in;
   end

   assign sc_wd = {srv_status_in, srv_cnt_in};

   // forward this cycle's writes into the prefetch of the new next channel
   always_comb begin
      pf_to_fwd_in  = to_we && (item.channel == next_ch_in);
      pf_to_data_in = item.timeout_ticks;
      pf_sc_fwd_in  = (sc_we && (srv_ch_in == next_ch_in)) || pf_to_fwd_in;
      pf_sc_data_in = sc_we ? sc_wd : '0;
      pf_sc_vld_in  = sc_vld_ff[next_ch_in];
      pf_fl_fwd_in  = sc_we && (srv_ch_in == next_ch_in);
      pf_fl_data_in = srv_flag_in;
      pf_fl_vld_in  = fl_vld_ff[next_ch_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_tmr_ff    <= REQ_TIMER_RESET;
         rcv_tmr_ff    <= '0;
         next_ch_ff    <= '0;
         srv_ch_ff     <= '0;
         srv_status_ff <= ST_PENDING;
         srv_cnt_ff    <= '0;
         srv_flag_ff   <= 1'b0;
         pf_to_fwd_ff  <= 1'b0;
         pf_sc_fwd_ff  <= 1'b0;
         pf_sc_vld_ff  <= 1'b0;
         pf_fl_fwd_ff  <= 1'b0;
         pf_fl_vld_ff  <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            sc_vld_ff[i] <= 1'b0;
            fl_vld_ff[i] <= 1'b0;
         end
      end else begin
         req_tmr_ff    <= req_tmr_in;
         rcv_tmr_ff    <= rcv_tmr_in;
         next_ch_ff    <= next_ch_in;
         srv_ch_ff     <= srv_ch_in;
         srv_status_ff <= srv_status_in;
         srv_cnt_ff    <= srv_cnt_in;
         srv_flag_ff   <= srv_flag_in;
         pf_to_fwd_ff  <= pf_to_fwd_in;
         pf_sc_fwd_ff  <= pf_sc_fwd_in;
         pf_sc_vld_ff  <= pf_sc_vld_in;
         pf_fl_fwd_ff  <= pf_fl_fwd_in;
         pf_fl_vld_ff  <= pf_fl_vld_in;
         if (sc_we) begin
            sc_vld_ff[srv_ch_in] <= 1'b1;
            fl_vld_ff[srv_ch_in] <= 1'b1;
         end
         // set-up drops the status and count back to zero
         if (to_we) begin
            sc_vld_ff[item.channel] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pf_to_data_ff <= pf_to_data_in;
      pf_sc_data_ff <= pf_sc_data_in;
      pf_fl_data_ff <= pf_fl_data_in;
   end

   bmps_ram #(.WIDTH(TIMER_W), .DEPTH(MAX_CHANNELS)) u_timeout_ram (
      .clock   (clock),
      .wr_en   (to_we),
      .wr_addr (item.channel),
      .wr_data (item.timeout_ticks),
      .rd_addr (next_ch_in),
      .rd_data (to_rd)
   );

   bmps_ram #(.WIDTH(SC_W), .DEPTH(MAX_CHANNELS)) u_status_ram (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (srv_ch_in),
      .wr_data (sc_wd),
      .rd_addr (next_ch_in),
      .rd_data (sc_rd)
   );

   bmps_ram #(.WIDTH(1), .DEPTH(MAX_CHANNELS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (srv_ch_in),
      .wr_data (srv_flag_in),
      .rd_addr (next_ch_in),
      .rd_data (fl_rd)
   );

   assign result = res;

endmodule

>>> rtl/bus_master_poll_scheduler_top.sv
// Top level of the bus master poll scheduler: handshake registers and wiring.
//
//  port group   direction  transfer
//  req_*        in         one item: tick, poll step or channel set-up
//  rsp_*        out        one result item per input item
//  p* (APB)     in/out     register writes and reads, pready always high
//
//  An item raises rsp_valid after its req transfer: the engine works on it while
//  it sits in the input register, and the result register takes it when it moves
//  on, which rsp_stall can hold off. One item per cycle is sustained while
//  rsp_stall is low; the engine's table update sets that rate.
//  Reset is synchronous and active high; it clears all table status at once
//  through per-entry valid bits, so no clearing pass follows it.
//  rsp_stall holds the result register, and req_stall rises only when the
//  input register is full and its item cannot move on.
`timescale 1ns / 1ps
module bus_master_poll_scheduler_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bmps_pkg::req_item_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bmps_pkg::rsp_item_type           rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bmps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bmps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import bmps_pkg::*;

   cfg_type      cfg;
   logic         in_vld_ff, in_vld_in;
   req_item_type in_item_ff;
   logic         out_vld_ff, out_vld_in;
   rsp_item_type out_item_ff;
   rsp_item_type eng_result;
   logic         req_xfer;
   logic         move;

   // advance the held item when the result register is free or draining
   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !move;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (move) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_data;
      end
      if (move) begin
         out_item_ff <= eng_result;
      end
   end

   bmps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bmps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_item_ff),
      .go     (move),
      .result (eng_result)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_item_ff;

endmodule

>>> rtl/bmps_checker.sv
// Port-level assertions for the poll scheduler and their bind to the top level.
`timescale 1ns / 1ps
module bmps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bmps_pkg::rsp_item_type rsp_data
);
   import bmps_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // reset empties both handshake stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a lap only ends with a new request
   a_lap_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lap_complete |-> rsp_data.request_sent)
      else $error("lap complete without request");

   // a good response leaves the channel OK with its error cleared
   a_resp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.response_accepted |->
         rsp_data.clear_timeout_error && (rsp_data.channel_status == ST_OK) &&
         !rsp_data.error_flag && !rsp_data.restore_settings)
      else $error("inconsistent response result");

   // a raised error comes with a fresh timeout mark and a set flag
   a_raise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.raise_timeout_error |->
         rsp_data.timeout_marked && rsp_data.error_flag &&
         (rsp_data.channel_status == ST_TIMEOUT))
      else $error("inconsistent timeout error result");

endmodule

bind bus_master_poll_scheduler_top bmps_checker u_bmps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the bus master poll scheduler with an in-step result predictor.
`timescale 1ns / 1ps
module tb_top;
   import bmps_pkg::*;

   // action code the block must ignore
   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   // receiver hold-off: start cycle and length
   localparam int         HOLD_AT     = 1500;
   localparam int         HOLD_CYCLES = 300;
   localparam int         LIMIT_NS    = 10_000_000;

   // Predicts one result per transfer and checks results in order.
   class poll_schedule_board;
      cfg_type             cfg;
      logic [TIMER_W-1:0]  reload_wait;
      logic [TIMER_W-1:0]  window_left;
      logic [CH_W-1:0]     upcoming_ch;
      logic [CH_W-1:0]     serving_ch;
      logic [TIMER_W-1:0]  ch_timeout [MAX_CHANNELS];
      logic [STATUS_W-1:0] ch_status  [MAX_CHANNELS];
      logic [ERR_W-1:0]    ch_misses  [MAX_CHANNELS];
      logic                ch_alarm   [MAX_CHANNELS];
      rsp_item_type        expected_results [$];
      int                  failures, items, results;
      int                  requests, accepts, marks, raises;

      function new();
         cfg.master_enable = 1'b0;
         cfg.channel_count = '0;
         cfg.request_pause = PAUSE_RESET;
         cfg.error_limit   = ERR_LIMIT_RESET;
         reload_wait = REQ_TIMER_RESET;
         window_left = '0;
         upcoming_ch = '0;
         serving_ch  = '0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            ch_timeout[c] = '0;
            ch_status[c]  = ST_PENDING;
            ch_misses[c]  = '0;
            ch_alarm[c]   = 1'b0;
         end
      endfunction

      function void apply_register(logic [1:0] idx, int unsigned value);
         case (idx)
            REG_MASTER_ENABLE: cfg.master_enable = value[0];
            REG_CHANNEL_COUNT: cfg.channel_count = value[COUNT_W-1:0];
            REG_REQUEST_PAUSE: cfg.request_pause = value[PAUSE_W-1:0];
            REG_ERROR_LIMIT:   cfg.error_limit   = value[ERR_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the predicted state by one accepted item and queue its result.
      function void absorb_item(req_item_type it);
         rsp_item_type      r;
         int                span;
         logic [CH_W:0]     after;
         logic [TIMER_W:0]  total;
         r = '0;
         items++;
         case (it.action)
            ACT_TICK: begin
               if (reload_wait != 0) reload_wait--;
               if (window_left != 0) window_left--;
            end
            ACT_POLL: begin
               span = (cfg.channel_count > MAX_CHANNELS) ? MAX_CHANNELS
                                                         : int'(cfg.channel_count);
               if (span != 0 && cfg.master_enable) begin
                  if (reload_wait == 0) begin
                     serving_ch = upcoming_ch;
                     after = serving_ch + 1'b1;
                     if (after >= span) begin
                        upcoming_ch = '0;
                        r.lap_complete = 1'b1;
                     end else begin
                        upcoming_ch = after[CH_W-1:0];
                     end
                     ch_status[serving_ch] = ST_PENDING;
                     r.request_sent = 1'b1;
                     window_left = ch_timeout[serving_ch];
                     total = ch_timeout[serving_ch] + cfg.request_pause;
                     reload_wait = (total > TIMER_MAX) ? TIMER_MAX : total[TIMER_W-1:0];
                     requests++;
                  end
                  if (window_left != 0) begin
                     if (it.response_ok) begin
                        r.response_accepted   = 1'b1;
                        r.clear_timeout_error = 1'b1;
                        ch_misses[serving_ch] = '0;
                        ch_alarm[serving_ch]  = 1'b0;
                        ch_status[serving_ch] = ST_OK;
                        window_left = '0;
                        accepts++;
                     end
                  end else begin
                     r.restore_settings = 1'b1;
                     if (ch_status[serving_ch] == ST_PENDING) begin
                        ch_status[serving_ch] = ST_TIMEOUT;
                        r.timeout_marked = 1'b1;
                        marks++;
                        if (ch_misses[serving_ch] < cfg.error_limit) begin
                           ch_misses[serving_ch]++;
                        end else begin
                           r.raise_timeout_error = 1'b1;
                           ch_alarm[serving_ch] = 1'b1;
                           raises++;
                        end
                     end
                  end
               end
            end
            ACT_SETUP: begin
               // error flag survives a set-up
               ch_timeout[it.channel] = it.timeout_ticks;
               ch_misses[it.channel]  = '0;
               ch_status[it.channel]  = ST_PENDING;
            end
            default: ;
         endcase
         r.channel_status  = ch_status[serving_ch];
         r.current_channel = serving_ch;
         r.error_flag      = ch_alarm[serving_ch];
         expected_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         results++;
         if (expected_results.size() == 0) begin
            $error("result arrived with nothing expected: %h", got);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("request_sent", 8'(want.request_sent), 8'(got.request_sent));
         compare_field("lap_complete", 8'(want.lap_complete), 8'(got.lap_complete));
         compare_field("response_accepted", 8'(want.response_accepted),
                       8'(got.response_accepted));
         compare_field("restore_settings", 8'(want.restore_settings),
                       8'(got.restore_settings));
         compare_field("timeout_marked", 8'(want.timeout_marked), 8'(got.timeout_marked));
         compare_field("raise_timeout_error", 8'(want.raise_timeout_error),
                       8'(got.raise_timeout_error));
         compare_field("clear_timeout_error", 8'(want.clear_timeout_error),
                       8'(got.clear_timeout_error));
         compare_field("channel_status", 8'(want.channel_status), 8'(got.channel_status));
         compare_field("current_channel", 8'(want.current_channel),
                       8'(got.current_channel));
         compare_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_item_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_data;
   logic                   psel      = 1'b0;
   logic                   penable   = 1'b0;
   logic                   pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr     = '0;
   logic [CSR_DATA_W-1:0]  pwdata    = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   poll_schedule_board     board = new();

   // channels whose timeout has been loaded, and the highest count ever in use
   logic [MAX_CHANNELS-1:0] written   = '0;
   int                      hi_water  = 0;
   int                      burst_left = 1;
   int                      settings_run = 0;

   // enable, count, pause, limit, items
   int phase_plan [8][5] = '{
      '{1,   2,   2, 5, 250},
      '{1,  64,   0, 0, 300},
      '{1, 127,   1, 7, 250},
      '{1,   1,   0, 3, 200},
      '{0,   5,   3, 2, 150},
      '{1,   5, 255, 7, 200},
      '{1, 100,   4, 1, 300},
      '{1,   3,   2, 5, 350}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bus_master_poll_scheduler_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Watch both channels; values read here are the ones the block saw at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.absorb_item(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   function automatic req_item_type make_item(logic [1:0] act, logic ok,
                                              logic [CH_W-1:0] ch,
                                              logic [TIMER_W-1:0] ticks);
      req_item_type it;
      it.action        = act;
      it.response_ok   = ok;
      it.channel       = ch;
      it.timeout_ticks = ticks;
      if (act == ACT_SETUP) written[ch] = 1'b1;
      return it;
   endfunction

   // First channel the round-robin could reach whose timeout was never loaded.
   function automatic int missing_channel();
      for (int c = 0; c < hi_water; c++) begin
         if (!written[c]) return c;
      end
      return -1;
   endfunction

   function automatic req_item_type random_item();
      int                 roll;
      int                 gap_ch;
      logic [1:0]         act;
      logic [TIMER_W-1:0] ticks;
      roll = $urandom_range(0, 99);
      if (roll < 45)      act = ACT_TICK;
      else if (roll < 85) act = ACT_POLL;
      else if (roll < 95) act = ACT_SETUP;
      else                act = ACT_UNUSED;
      // short timeouts so windows open and close often
      ticks = ($urandom_range(0, 9) == 0) ? TIMER_W'($urandom_range(0, 40))
                                          : TIMER_W'($urandom_range(0, 8));
      gap_ch = missing_channel();
      if (act == ACT_POLL && gap_ch >= 0)
         return make_item(ACT_SETUP, 1'($urandom_range(0, 1)), CH_W'(gap_ch), ticks);
      return make_item(act, 1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 63)), ticks);
   endfunction

   // Hold the item until a transfer happens; valid stays high throughout.
   task automatic send_item(input req_item_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send inside a burst; drop valid for a random gap when the burst runs out.
   task automatic offer(input req_item_type it);
      int gap;
      send_item(it);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
   endtask

   task automatic put(input logic [1:0] act, input logic ok, input logic [CH_W-1:0] ch,
                      input logic [TIMER_W-1:0] ticks);
      offer(make_item(act, ok, ch, ticks));
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int unsigned value);
      int eff;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      board.apply_register(idx, value);
      if (idx == REG_CHANNEL_COUNT) begin
         eff = value & 32'h7F;
         if (eff > MAX_CHANNELS) eff = MAX_CHANNELS;
         if (eff > hi_water) hi_water = eff;
      end
   endtask

   task automatic program_all(input int en, input int cnt, input int pause, input int lim);
      hold_until_drained();
      csr_write(REG_MASTER_ENABLE, en);
      csr_write(REG_CHANNEL_COUNT, cnt);
      csr_write(REG_REQUEST_PAUSE, pause);
      csr_write(REG_ERROR_LIMIT, lim);
      settings_run++;
   endtask

   // Receiver: rotate among stall patterns, with one long hold-off that backs up the block.
   initial begin : result_side
      int cycles = 0;
      int mode   = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= (cycles % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 1);
         endcase
         if (cycles % 97 == 0) mode = $urandom_range(0, 2);
      end
   end

   initial begin : stimulus
      int drain;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: polling disabled, ignored action with every field high
      put(ACT_POLL, 1'b1, '0, '0);
      put(ACT_UNUSED, 1'b1, 6'd63, 16'hFFFF);
      put(ACT_SETUP, 1'b0, 6'd63, 16'hAAAA);
      put(ACT_SETUP, 1'b1, 6'd63, 16'h5555);
      put(ACT_SETUP, 1'b0, 6'd0, 16'd0);
      put(ACT_SETUP, 1'b0, 6'd1, 16'd3);
      put(ACT_TICK, 1'b0, '0, '0);

      // enabled but zero channels: poll stays idle
      hold_until_drained();
      csr_write(REG_MASTER_ENABLE, 1);
      put(ACT_POLL, 1'b1, '0, '0);

      // two channels, no pause, error raised on the first timeout
      hold_until_drained();
      csr_write(REG_CHANNEL_COUNT, 2);
      csr_write(REG_REQUEST_PAUSE, 0);
      csr_write(REG_ERROR_LIMIT, 0);
      repeat (5) put(ACT_TICK, 1'b0, '0, '0);
      put(ACT_POLL, 1'b0, '0, '0);   // zero timeout: window closed at once
      put(ACT_POLL, 1'b1, '0, '0);   // next channel, lap wraps, response taken
      put(ACT_POLL, 1'b0, '0, '0);   // closed window on a channel already ok
      repeat (3) put(ACT_TICK, 1'b0, '0, '0);
      put(ACT_POLL, 1'b1, '0, '0);   // timeout again, error stays raised
      put(ACT_SETUP, 1'b0, 6'd0, 16'd3);  // set-up keeps the error flag

      for (int p = 0; p < 8; p++) begin
         program_all(phase_plan[p][0], phase_plan[p][1], phase_plan[p][2], phase_plan[p][3]);
         for (int n = 0; n < phase_plan[p][4]; n++) offer(random_item());
      end

      // saturating timer sum on a single channel; every channel the pointer
      // can hold next gets the largest timeout
      hold_until_drained();
      csr_write(REG_CHANNEL_COUNT, 1);
      csr_write(REG_REQUEST_PAUSE, 255);
      csr_write(REG_ERROR_LIMIT, 7);
      for (int c = 0; c < 3; c++) put(ACT_SETUP, 1'b1, CH_W'(c), 16'hFFFF);
      hold_until_drained();
      drain = int'(board.reload_wait);
      for (int n = 0; n < drain; n++) send_item(make_item(ACT_TICK, 1'b0, '0, '0));
      put(ACT_POLL, 1'b0, '0, '0);   // window open, no response yet
      put(ACT_POLL, 1'b1, '0, '0);

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (board.expected_results.size() != 0) begin
         $error("%0d expected results never arrived", board.expected_results.size());
         board.failures++;
      end
      $display("Covered %0d items and %0d results across %0d register settings.",
               board.items, board.results, settings_run + 3);
      $display("Saw %0d requests, %0d responses taken, %0d timeouts marked, %0d errors raised.",
               board.requests, board.accepts, board.marks, board.raises);
      if (board.failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
rtl/bmps_pkg.sv
rtl/bmps_ram.sv
rtl/bmps_csr.sv
rtl/bmps_engine.sv
rtl/bus_master_poll_scheduler_top.sv
rtl/bmps_checker.sv
tb/sv/tb_top.sv
